// ===== rtl/bsas_pkg.sv =====
// ----------------------------------------------------------------------------
// bsas_pkg
// Shared types, codes and sizes for the bit-serial acknowledged sender.
// ----------------------------------------------------------------------------
package bsas_pkg;

  localparam int ID_BITS_DEF     = 23;
  localparam int BYTE_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int OP_W       = 2;
  localparam int COUNT_W    = 12;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_INITIAL_WAIT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WAIT_STEP     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GIVE_UP_LIMIT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ID_BIT_GAP    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_END_CODE      = 3'd4;

  // Register reset values.
  localparam logic [10:0] INITIAL_WAIT_RST  = 11'd10;
  localparam logic [7:0]  WAIT_STEP_RST     = 8'd10;
  localparam logic [10:0] GIVE_UP_LIMIT_RST = 11'd1000;
  localparam logic [7:0]  ID_BIT_GAP_RST    = 8'd50;
  localparam logic [7:0]  END_CODE_RST      = 8'd4;

  // Request kinds as they arrive on the input channel.
  localparam logic [1:0] KIND_SEND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK      = 2'd1;
  localparam logic [1:0] KIND_ACK       = 2'd2;
  localparam logic [1:0] KIND_SEND_ID   = 2'd3;

  // Operations handed from the front end to the engine.
  localparam logic [OP_W-1:0] OP_SEND_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK      = 2'd1;
  localparam logic [OP_W-1:0] OP_ACK       = 2'd2;
  localparam logic [OP_W-1:0] OP_SEND_ID   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_BYTE_DONE = 2'd1;
  localparam logic [1:0] ST_ID_DONE   = 2'd2;
  localparam logic [1:0] ST_TIMEOUT   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  letter;
    logic [22:0] sender_id;
  } in_item_t;

  typedef struct packed {
    logic       bit_valid;
    logic       bit_value;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [10:0] initial_wait;
    logic [7:0]  wait_step;
    logic [10:0] give_up_limit;
    logic [7:0]  id_bit_gap;
    logic [7:0]  end_code;
  } cfg_t;

  // Width of the shift word that holds either a byte or a sender id.
  function automatic int shift_width(input int id_bits, input int byte_bits);
    return (id_bits > byte_bits) ? id_bits : byte_bits;
  endfunction

endpackage

// ===== rtl/bsas_fifo.sv =====
// ----------------------------------------------------------------------------
// bsas_fifo
// Small register queue between the front end and the engine.
// ----------------------------------------------------------------------------
module bsas_fifo
  import bsas_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/bsas_front.sv =====
// ----------------------------------------------------------------------------
// bsas_front
// Accepts requests, turns the kind into an engine operation and builds the
// shift word (byte or sender id) that the engine will send.
// ----------------------------------------------------------------------------
module bsas_front
  import bsas_pkg::*;
#(
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int BYTE_BITS = BYTE_BITS_DEF
) (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output logic [OP_W+shift_width(ID_BITS, BYTE_BITS)-1:0] q_entry
);

  localparam int SW_W  = shift_width(ID_BITS, BYTE_BITS);
  localparam int EXT_W = SW_W + 32;
  localparam logic [SW_W-1:0] BYTE_MASK = SW_W'((64'd1 << BYTE_BITS) - 64'd1);
  localparam logic [SW_W-1:0] ID_MASK   = SW_W'((64'd1 << ID_BITS) - 64'd1);

  logic [EXT_W-1:0] letter_ext, sid_ext;
  logic [OP_W-1:0]  op;
  logic [SW_W-1:0]  word;

  assign letter_ext = EXT_W'(in_data.letter);
  assign sid_ext    = EXT_W'(in_data.sender_id);

  always_comb begin
    unique case (in_data.kind)
      KIND_SEND_BYTE: begin
        op   = OP_SEND_BYTE;
        word = letter_ext[SW_W-1:0] & BYTE_MASK;
      end
      KIND_TICK: begin
        op   = OP_TICK;
        word = '0;
      end
      KIND_ACK: begin
        op   = OP_ACK;
        word = '0;
      end
      KIND_SEND_ID: begin
        op   = OP_SEND_ID;
        word = sid_ext[SW_W-1:0] & ID_MASK;
      end
      default: begin
        op   = OP_TICK;
        word = '0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_entry  = {op, word};

endmodule

// ===== rtl/bsas_engine.sv =====
// ----------------------------------------------------------------------------
// bsas_engine
// Carries out queued operations against the sender state and registers the
// results; a spill register holds the second result of a two-bit request.
// ----------------------------------------------------------------------------
module bsas_engine
  import bsas_pkg::*;
#(
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int BYTE_BITS = BYTE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  logic [OP_W+shift_width(ID_BITS, BYTE_BITS)-1:0] q_entry,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int SW_W    = shift_width(ID_BITS, BYTE_BITS);
  localparam int ENTRY_W = OP_W + SW_W;
  localparam int IDX_W   = (SW_W > 1) ? $clog2(SW_W) : 1;
  localparam int CMP_W   = (SW_W > 8) ? SW_W : 8;
  localparam logic [IDX_W-1:0] BYTE_TOP = IDX_W'(BYTE_BITS - 1);
  localparam logic [IDX_W-1:0] ID_TOP   = IDX_W'(ID_BITS - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WAIT = 2'd1;
  localparam logic [1:0] MODE_ID   = 2'd2;

  logic [1:0]         mode_r, mode_nxt;
  logic [SW_W-1:0]    word_r, word_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               ack_r, ack_nxt;
  logic [COUNT_W-1:0] poll_r, poll_nxt;
  logic [COUNT_W-1:0] limit_r, limit_nxt;
  logic               cur_r, cur_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;
  logic               spill_valid_r, spill_valid_nxt;
  out_item_t          spill_r, spill_nxt;

  logic [OP_W-1:0]    q_op;
  logic [SW_W-1:0]    q_word;
  logic               advance, take;
  logic [1:0]         res_n;
  out_item_t          res0, res1;
  logic [IDX_W-1:0]   idx_dn;
  logic [COUNT_W-1:0] poll_inc;
  logic [7:0]         gap_eff;

  // Byte bit sender: sends the bit at bs_idx and, when no acknowledge is
  // needed for it, the following bit in the same step.
  logic               bs_start;
  logic [SW_W-1:0]    bs_word;
  logic [IDX_W-1:0]   bs_idx, bs_idx1;
  logic               bs_is_end, bs_bit0, bs_bit1, bs_need0, bs_need1;
  logic               bs_two, bs_wait;

  assign q_op   = q_entry[ENTRY_W-1 -: OP_W];
  assign q_word = q_entry[SW_W-1:0];
  assign idx_dn = idx_r - 1'b1;

  assign poll_inc = (poll_r == COUNT_MAX) ? poll_r : poll_r + 1'b1;
  assign gap_eff  = (cfg.id_bit_gap == '0) ? 8'd1 : cfg.id_bit_gap;

  assign bs_start  = (q_op == OP_SEND_BYTE);
  assign bs_word   = bs_start ? q_word : word_r;
  assign bs_idx    = bs_start ? BYTE_TOP : idx_dn;
  assign bs_idx1   = bs_idx - 1'b1;
  assign bs_is_end = (CMP_W'(bs_word) == CMP_W'(cfg.end_code));
  assign bs_bit0   = bs_word[bs_idx];
  assign bs_bit1   = bs_word[bs_idx1];
  assign bs_need0  = !(bs_is_end && (bs_idx == '0));
  assign bs_need1  = !(bs_is_end && (bs_idx1 == '0));
  assign bs_two    = !(bs_need0 && !ack_r) && (bs_idx != '0);
  assign bs_wait   = bs_two ? bs_need1 : (bs_need0 && !ack_r);

  assign advance = !out_valid_r || !out_stall;
  assign take    = advance && !spill_valid_r && !q_empty;
  assign q_pop   = take;

  always_comb begin
    mode_nxt  = mode_r;
    word_nxt  = word_r;
    idx_nxt   = idx_r;
    ack_nxt   = ack_r;
    poll_nxt  = poll_r;
    limit_nxt = limit_r;
    cur_nxt   = cur_r;
    res_n     = 2'd0;
    res0      = '0;
    res1      = '0;

    if (take) begin
      unique case (q_op) inside
        OP_SEND_BYTE, OP_ACK: begin
          if (q_op == OP_ACK && mode_r != MODE_WAIT) begin
            ack_nxt = 1'b1;
          end else if (q_op == OP_ACK && idx_r == '0) begin
            res_n       = 2'd1;
            res0.status = ST_BYTE_DONE;
            mode_nxt    = MODE_IDLE;
          end else if (q_op == OP_ACK || mode_r == MODE_IDLE) begin
            word_nxt       = bs_word;
            ack_nxt        = 1'b0;
            idx_nxt        = bs_two ? bs_idx1 : bs_idx;
            cur_nxt        = bs_two ? bs_bit1 : bs_bit0;
            res0.bit_valid = 1'b1;
            res0.bit_value = bs_bit0;
            res0.status    = (!bs_two && !bs_wait) ? ST_BYTE_DONE : ST_NONE;
            res1.bit_valid = 1'b1;
            res1.bit_value = bs_bit1;
            res1.status    = bs_wait ? ST_NONE : ST_BYTE_DONE;
            res_n          = bs_two ? 2'd2 : 2'd1;
            mode_nxt       = bs_wait ? MODE_WAIT : MODE_IDLE;
            if (bs_wait) begin
              poll_nxt  = '0;
              limit_nxt = COUNT_W'(cfg.initial_wait);
            end
          end
        end
        OP_TICK: begin
          if (mode_r == MODE_WAIT) begin
            poll_nxt = poll_inc;
            if (limit_r > COUNT_W'(cfg.give_up_limit)) begin
              res_n       = 2'd1;
              res0.status = ST_TIMEOUT;
              mode_nxt    = MODE_IDLE;
              ack_nxt     = 1'b0;
            end else if (poll_r > limit_r) begin
              // Resend the same bit and allow a longer wait for it.
              limit_nxt      = limit_r + COUNT_W'(cfg.wait_step);
              res_n          = 2'd1;
              res0.bit_valid = 1'b1;
              res0.bit_value = cur_r;
            end
          end else if (mode_r == MODE_ID) begin
            poll_nxt = poll_inc;
            if (poll_inc >= COUNT_W'(gap_eff)) begin
              res_n = 2'd1;
              if (idx_r == '0) begin
                res0.status = ST_ID_DONE;
                mode_nxt    = MODE_IDLE;
              end else begin
                idx_nxt        = idx_dn;
                cur_nxt        = word_r[idx_dn];
                res0.bit_valid = 1'b1;
                res0.bit_value = word_r[idx_dn];
                poll_nxt       = '0;
              end
            end
          end
        end
        OP_SEND_ID: begin
          if (mode_r == MODE_IDLE) begin
            word_nxt       = q_word;
            idx_nxt        = ID_TOP;
            cur_nxt        = q_word[ID_TOP];
            poll_nxt       = '0;
            mode_nxt       = MODE_ID;
            res_n          = 2'd1;
            res0.bit_valid = 1'b1;
            res0.bit_value = q_word[ID_TOP];
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end

    res0.last = (res_n == 2'd1);
    res1.last = 1'b1;
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_nxt         = out_r;
    spill_valid_nxt = spill_valid_r;
    spill_nxt       = spill_r;
    if (advance) begin
      if (spill_valid_r) begin
        out_nxt         = spill_r;
        out_valid_nxt   = 1'b1;
        spill_valid_nxt = 1'b0;
      end else if (res_n != 2'd0) begin
        out_nxt       = res0;
        out_valid_nxt = 1'b1;
        if (res_n == 2'd2) begin
          spill_nxt       = res1;
          spill_valid_nxt = 1'b1;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      word_r        <= '0;
      idx_r         <= '0;
      ack_r         <= 1'b0;
      poll_r        <= '0;
      limit_r       <= '0;
      cur_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      spill_valid_r <= 1'b0;
    end else begin
      mode_r        <= mode_nxt;
      word_r        <= word_nxt;
      idx_r         <= idx_nxt;
      ack_r         <= ack_nxt;
      poll_r        <= poll_nxt;
      limit_r       <= limit_nxt;
      cur_r         <= cur_nxt;
      out_valid_r   <= out_valid_nxt;
      spill_valid_r <= spill_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    spill_r <= spill_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/bit_serial_ack_sender.sv =====
// Flow: an accepted request is written into the queue; the engine takes it from the
// queue head and registers its result; a second result waits in the spill register.
// Throughput: one request per cycle while the output is not stalled, set by the
// single engine update; a request sending two bits holds the engine for the spill.
// Reset (synchronous, active low) empties the queue, idles the sender and restores
// every configuration register to its default.
// ----------------------------------------------------------------------------
// bit_serial_ack_sender
// Sends bytes bit by bit with per-bit acknowledge and retry, and sender ids
// with a fixed tick gap; configured through an APB-style register port.
// ----------------------------------------------------------------------------
module bit_serial_ack_sender
  import bsas_pkg::*;
#(
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int BYTE_BITS   = BYTE_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int ENTRY_W = OP_W + shift_width(ID_BITS, BYTE_BITS);

  logic [10:0] initial_wait_r, initial_wait_nxt;
  logic [7:0]  wait_step_r, wait_step_nxt;
  logic [10:0] give_up_limit_r, give_up_limit_nxt;
  logic [7:0]  id_bit_gap_r, id_bit_gap_nxt;
  logic [7:0]  end_code_r, end_code_nxt;
  logic [REG_IDX_W-1:0] reg_index;
  logic        reg_write;
  cfg_t        cfg;

  logic               q_push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0] q_push_entry, q_pop_entry;

  assign cfg_pready = 1'b1;
  assign reg_index  = cfg_paddr[4:2];
  assign reg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    initial_wait_nxt  = initial_wait_r;
    wait_step_nxt     = wait_step_r;
    give_up_limit_nxt = give_up_limit_r;
    id_bit_gap_nxt    = id_bit_gap_r;
    end_code_nxt      = end_code_r;
    if (reg_write) begin
      unique case (reg_index)
        REG_INITIAL_WAIT:  initial_wait_nxt  = cfg_pwdata[10:0];
        REG_WAIT_STEP:     wait_step_nxt     = cfg_pwdata[7:0];
        REG_GIVE_UP_LIMIT: give_up_limit_nxt = cfg_pwdata[10:0];
        REG_ID_BIT_GAP:    id_bit_gap_nxt    = cfg_pwdata[7:0];
        REG_END_CODE:      end_code_nxt      = cfg_pwdata[7:0];
        default:           end_code_nxt      = end_code_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_INITIAL_WAIT:  cfg_prdata = CFG_DATA_W'(initial_wait_r);
      REG_WAIT_STEP:     cfg_prdata = CFG_DATA_W'(wait_step_r);
      REG_GIVE_UP_LIMIT: cfg_prdata = CFG_DATA_W'(give_up_limit_r);
      REG_ID_BIT_GAP:    cfg_prdata = CFG_DATA_W'(id_bit_gap_r);
      REG_END_CODE:      cfg_prdata = CFG_DATA_W'(end_code_r);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_wait_r  <= INITIAL_WAIT_RST;
      wait_step_r     <= WAIT_STEP_RST;
      give_up_limit_r <= GIVE_UP_LIMIT_RST;
      id_bit_gap_r    <= ID_BIT_GAP_RST;
      end_code_r      <= END_CODE_RST;
    end else begin
      initial_wait_r  <= initial_wait_nxt;
      wait_step_r     <= wait_step_nxt;
      give_up_limit_r <= give_up_limit_nxt;
      id_bit_gap_r    <= id_bit_gap_nxt;
      end_code_r      <= end_code_nxt;
    end
  end

  assign cfg.initial_wait  = initial_wait_r;
  assign cfg.wait_step     = wait_step_r;
  assign cfg.give_up_limit = give_up_limit_r;
  assign cfg.id_bit_gap    = id_bit_gap_r;
  assign cfg.end_code      = end_code_r;

  bsas_front #(
    .ID_BITS   (ID_BITS),
    .BYTE_BITS (BYTE_BITS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_push_entry)
  );

  bsas_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_entry),
    .empty     (q_empty)
  );

  bsas_engine #(
    .ID_BITS   (ID_BITS),
    .BYTE_BITS (BYTE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_entry   (q_pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
